/* rtl/mtft_pkg.sv */
// Shared types and constants for the market tick feature table.
package mtft_pkg;

	localparam int NUM_SYMBOLS_DEF = 1024;
	localparam int MAX_AW          = 16;
	localparam int IDX_W           = 10;
	localparam int PRICE_W         = 32;
	localparam int SPREAD_W        = 33;
	localparam int IMB_W           = 16;
	localparam int SUM_W           = 64;
	localparam int TIME_W          = 64;
	localparam int QUOT_W          = 32;
	localparam int DEN_W           = 33;
	localparam int NUM_W           = 64;
	localparam int Q14_SHIFT       = 14;
	localparam int IN_TDATA_W      = 208;
	localparam int OUT_TDATA_W     = 376;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  tick_time;
		logic [PRICE_W-1:0] ask_qty;
		logic [PRICE_W-1:0] bid_qty;
		logic [PRICE_W-1:0] ask_px;
		logic [PRICE_W-1:0] bid_px;
		logic [IDX_W-1:0]   symbol_index;
	} in_data_t;

	typedef struct packed {
		logic [TIME_W-1:0]          last_time;
		logic [SUM_W-1:0]           vwap_volume_sum;
		logic [SUM_W-1:0]           vwap_price_sum;
		logic [PRICE_W-1:0]         last_mid;
		logic [PRICE_W-1:0]         last_ask;
		logic [PRICE_W-1:0]         last_bid;
		logic [PRICE_W-1:0]         micro_price;
		logic signed [IMB_W-1:0]    imbalance;
		logic signed [SPREAD_W-1:0] spread;
	} rec_data_t;

	typedef struct packed {
		logic      known;
		rec_data_t data;
	} rec_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

/* rtl/mtft_ram.sv */
// Generic single-port-write, registered-read RAM.
module mtft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* rtl/mtft_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module mtft_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mtft_pkg::div_req_t        req,
	output logic                      busy,
	output logic [mtft_pkg::QUOT_W-1:0] quot
);
	import mtft_pkg::*;

	localparam int CW = $clog2(QUOT_W);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] nsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, nsh_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QUOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= DEN_W'(req.num[NUM_W-1:QUOT_W]);
			nsh_q  <= req.num[QUOT_W-1:0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			nsh_q  <= {nsh_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule

/* rtl/market_tick_feature_table.sv */
// Top level of the market tick feature table: per-symbol record store and tick update.
// Each request reads one symbol's record from a single record RAM (one record per symbol,
// registered read); an in-range tick also updates it and writes it back. A read request, a
// tick with zero total volume, or an index at or beyond NUM_SYMBOLS passes through the read
// and multiply states to write-back; a tick with nonzero volume first starts the two
// 32-step dividers that form the imbalance and the micro-price in parallel and waits for
// both. After reset the RAM is swept to zero, one record a cycle, with s_tready held low;
// the next request is taken once the current result sits in the output register.
module market_tick_feature_table #(
	parameter int NUM_SYMBOLS = mtft_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// symbol_index, bid_px, ask_px, bid_qty, ask_qty, tick_time
	input  logic [mtft_pkg::IN_TDATA_W-1:0]  s_tdata,
	// command
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// spread, imbalance, micro_price, last_bid, last_ask, last_mid,
	// vwap_price_sum, vwap_volume_sum, last_time
	output logic [mtft_pkg::OUT_TDATA_W-1:0] m_tdata,
	// known
	output logic                             m_tuser
);
	import mtft_pkg::*;

	localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int RW = $bits(rec_t);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MUL, S_STRT, S_DIV, S_WB} state_t;

	state_t state_q;

	in_data_t in_d;
	logic     s_acc;

	logic [AW-1:0]         clr_q;
	logic                  cmd_q;
	logic                  inr_q;
	logic [AW-1:0]         addr_q;
	logic [PRICE_W-1:0]    bid_q;
	logic [PRICE_W-1:0]    ask_q;
	logic [PRICE_W-1:0]    mid_q;
	logic [DEN_W-1:0]      tot_q;
	logic [SPREAD_W-1:0]   spr_q;
	logic [PRICE_W-1:0]    diff_q;
	logic                  bge_q;
	logic [PRICE_W-1:0]    span_q;
	logic [PRICE_W-1:0]    volhi_q;
	logic [PRICE_W-1:0]    lo_q;
	logic [TIME_W-1:0]     time_q;
	logic [SUM_W-1:0]      vwinc_q;
	logic [NUM_W-1:0]      mnum_q;
	rec_t                  rec_q;

	logic [MAX_AW-1:0]     idx_ext;
	logic [PRICE_W:0]      bid_ask_sum;
	logic                  bv_ge_av;
	logic                  ask_ge_bid;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	rec_t                  ram_wdata;
	rec_t                  ram_rdata;
	rec_t                  new_rec;

	div_req_t              imb_req;
	div_req_t              mic_req;
	logic                  imb_busy;
	logic                  mic_busy;
	logic [QUOT_W-1:0]     imb_quot;
	logic [QUOT_W-1:0]     mic_quot;
	logic [IMB_W-1:0]      imb_mag;
	logic                  tick_upd;
	logic                  out_free;

	logic                  m_valid_q;
	rec_t                  m_rec_q;

	assign in_d        = in_data_t'(s_tdata[$bits(in_data_t)-1:0]);
	assign s_tready    = (state_q == S_IDLE);
	assign s_acc       = s_tvalid && s_tready;
	assign idx_ext     = {{(MAX_AW-IDX_W){1'b0}}, in_d.symbol_index};
	assign bid_ask_sum = {1'b0, in_d.bid_px} + {1'b0, in_d.ask_px};
	assign bv_ge_av    = in_d.bid_qty >= in_d.ask_qty;
	assign ask_ge_bid  = in_d.ask_px >= in_d.bid_px;
	assign out_free    = !m_valid_q || m_tready;
	assign tick_upd    = (cmd_q == CMD_TICK) && inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == S_WB && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_SYMBOLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_MUL;
				S_MUL:  state_q <= (tick_upd && tot_q != '0) ? S_STRT : S_WB;
				S_STRT: state_q <= S_DIV;
				S_DIV: begin
					if (!imb_busy && !mic_busy) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q   <= s_tuser;
			inr_q   <= {1'b0, idx_ext} < (MAX_AW+1)'(NUM_SYMBOLS);
			addr_q  <= AW'(idx_ext);
			bid_q   <= in_d.bid_px;
			ask_q   <= in_d.ask_px;
			mid_q   <= bid_ask_sum[PRICE_W:1];
			tot_q   <= {1'b0, in_d.bid_qty} + {1'b0, in_d.ask_qty};
			spr_q   <= {1'b0, in_d.ask_px} - {1'b0, in_d.bid_px};
			bge_q   <= bv_ge_av;
			diff_q  <= bv_ge_av ? in_d.bid_qty - in_d.ask_qty
			                    : in_d.ask_qty - in_d.bid_qty;
			span_q  <= ask_ge_bid ? in_d.ask_px - in_d.bid_px
			                      : in_d.bid_px - in_d.ask_px;
			volhi_q <= ask_ge_bid ? in_d.bid_qty : in_d.ask_qty;
			lo_q    <= ask_ge_bid ? in_d.bid_px : in_d.ask_px;
			time_q  <= in_d.tick_time;
		end
		if (state_q == S_MUL) begin
			rec_q   <= ram_rdata;
			vwinc_q <= SUM_W'(mid_q * tot_q);
			mnum_q  <= span_q * volhi_q;
		end
		if (state_q == S_WB && out_free) begin
			m_rec_q <= inr_q ? (tick_upd ? new_rec : rec_q) : '0;
		end
	end

	assign imb_req.start = (state_q == S_STRT);
	assign imb_req.num   = {{(NUM_W-PRICE_W-Q14_SHIFT){1'b0}}, diff_q, {Q14_SHIFT{1'b0}}};
	assign imb_req.den   = tot_q;
	assign mic_req.start = (state_q == S_STRT);
	assign mic_req.num   = mnum_q;
	assign mic_req.den   = tot_q;

	mtft_div u_imb_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (imb_req),
		.busy   (imb_busy),
		.quot   (imb_quot)
	);

	mtft_div u_mic_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mic_req),
		.busy   (mic_busy),
		.quot   (mic_quot)
	);

	assign imb_mag = imb_quot[IMB_W-1:0];

	always_comb begin
		new_rec                      = rec_q;
		new_rec.known                = 1'b1;
		new_rec.data.spread          = spr_q;
		new_rec.data.last_bid        = bid_q;
		new_rec.data.last_ask        = ask_q;
		new_rec.data.last_mid        = mid_q;
		new_rec.data.last_time       = time_q;
		new_rec.data.vwap_price_sum  = rec_q.data.vwap_price_sum + vwinc_q;
		new_rec.data.vwap_volume_sum = rec_q.data.vwap_volume_sum + SUM_W'(tot_q);
		if (tot_q != '0) begin
			new_rec.data.imbalance   = bge_q ? imb_mag : IMB_W'(-imb_mag);
			new_rec.data.micro_price = lo_q + mic_quot;
		end
	end

	assign ram_we    = (state_q == S_CLR) || (state_q == S_WB && out_free && tick_upd);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_CLR) ? '0 : new_rec;

	mtft_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_SYMBOLS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (state_q == S_RD),
		.rd_addr (addr_q),
		.rd_data (ram_rdata)
	);

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_rec_q.known;
	assign m_tdata  = {{(OUT_TDATA_W-$bits(rec_data_t)){1'b0}}, m_rec_q.data};

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !s_tready)
		else $error("request accepted during clearing sweep");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		imb_req.start |-> (tot_q != '0 && tick_upd))
		else $error("divider started without a nonzero total");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLR || state_q == S_WB))
		else $error("record write outside write-back");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && out_free) |=> (m_valid_q && state_q == S_IDLE))
		else $error("result not loaded at write-back");
endmodule
